// ----- hdl/nearest_point_manhattan_search_assert.svh -----
// assertion macros shared by the search block
`ifndef NEAREST_POINT_MANHATTAN_SEARCH_ASSERT_SVH
`define NEAREST_POINT_MANHATTAN_SEARCH_ASSERT_SVH

// same-cycle implication under synchronous reset
`define NPMS_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define NPMS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hdl/npms_pkg.sv -----
`timescale 1ns / 1ps

package npms_pkg;

   localparam int CoordBits = 10;
   localparam int DistBits  = CoordBits + 1;
   localparam int IndexBits = 6;
   localparam int CountBits = 7;
   localparam int CountMax  = (1 << CountBits) - 1;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register select, taken from byte address bit 2
   localparam logic REG_ENTRY_COUNT = 1'b0;

   typedef struct packed {
      logic                 req_type;
      logic [IndexBits-1:0] entry_index;
      logic [CoordBits-1:0] coord_x;
      logic [CoordBits-1:0] coord_y;
   } req_item_type;

   typedef struct packed {
      logic                 found;
      logic [IndexBits-1:0] nearest_index;
      logic [DistBits-1:0]  best_distance;
   } rsp_item_type;

   typedef struct packed {
      logic [CoordBits-1:0] coord_x;
      logic [CoordBits-1:0] coord_y;
   } pos_type;

   // control handed to the distance unit with each table read
   typedef struct packed {
      logic valid;
      logic first;
   } dist_ctl_type;

endpackage

// ----- hdl/nearest_point_manhattan_search.sv -----
`timescale 1ns / 1ps
// channel   ports        payload / use
// request   req_*        write item (store x,y at slot) or query item (point)
// response  rsp_*        one item per query: found, nearest_index, best_distance
// config    csr_*        apb write/read of entry_count at byte 0
//
// a write item is taken and produces nothing
// a query passes through scan, drain and done, or goes straight to done on an
//   empty search, limit = min(entry_count, MAX_ENTRIES); rsp_valid is set
//   from a register that done loads once the output register is free
// the table ram has one read port, so one entry is compared per cycle;
//   after the last read, drain waits for the read tag and distance unit to empty
// req_ready is high only while the sequencer is idle; a finished response
//   sits in the output register while the next item is taken, and a query
//   that finishes while that register is still full waits in done
// synchronous active-high reset clears control and entry_count, not the table

module nearest_point_manhattan_search #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  npms_pkg::req_item_type req_item,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output npms_pkg::rsp_item_type rsp_item,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

`include "nearest_point_manhattan_search_assert.svh"

   localparam int AddrBits = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int MaxLimit = (MAX_ENTRIES > npms_pkg::CountMax) ? npms_pkg::CountMax
                                                                : MAX_ENTRIES;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                        state_ff;
   logic [npms_pkg::CountBits-1:0]   count_ff;
   logic [npms_pkg::CountBits-1:0]   limit_ff;
   logic [npms_pkg::CountBits-1:0]   limit_in;
   logic [AddrBits-1:0]              scan_ff;
   logic                             scan_last;
   npms_pkg::pos_type                query_ff;
   logic                             found_ff;

   // read pipeline tag, lines up with registered ram data
   logic                             rd_valid_ff;
   logic                             rd_first_ff;
   logic [AddrBits-1:0]              rd_idx_ff;

   logic                             rsp_valid_ff;
   npms_pkg::rsp_item_type           rsp_item_ff;
   logic                             rsp_load;

   logic                             req_fire;
   logic                             tbl_we;
   npms_pkg::pos_type                tbl_wdata;
   npms_pkg::pos_type                tbl_rdata;
   logic                             csr_write;

   npms_pkg::dist_ctl_type           dist_ctl;
   logic                             dist_busy;
   logic [AddrBits-1:0]              dist_best_i;
   logic [npms_pkg::DistBits-1:0]    dist_best_d;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // out-of-range slots are dropped
   assign tbl_we = req_fire && (req_item.req_type == npms_pkg::REQ_WRITE)
                   && (int'(req_item.entry_index) < MAX_ENTRIES);
   assign tbl_wdata.coord_x = req_item.coord_x;
   assign tbl_wdata.coord_y = req_item.coord_y;

   // count above the table size saturates
   assign limit_in = (int'(count_ff) > MaxLimit) ? npms_pkg::CountBits'(MaxLimit)
                                                 : count_ff;
   assign scan_last = (int'(scan_ff) + 1 == int'(limit_ff));

   // response slot free or being emptied
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == npms_pkg::REG_ENTRY_COUNT) ? 32'(count_ff) : 32'd0;

   npms_ram #(
      .WIDTH ($bits(npms_pkg::pos_type)),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (AddrBits'(req_item.entry_index)),
      .wdata (tbl_wdata),
      .raddr (scan_ff),
      .rdata (tbl_rdata)
   );

   assign dist_ctl.valid = rd_valid_ff;
   assign dist_ctl.first = rd_first_ff;

   npms_dist_unit #(
      .IDX_BITS (AddrBits)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .ctl           (dist_ctl),
      .idx           (rd_idx_ff),
      .query         (query_ff),
      .entry         (tbl_rdata),
      .busy          (dist_busy),
      .best_index    (dist_best_i),
      .best_distance (dist_best_d)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == npms_pkg::REG_ENTRY_COUNT)) begin
            count_ff <= csr_pwdata[npms_pkg::CountBits-1:0];
         end

         rd_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_item.req_type == npms_pkg::REQ_QUERY)) begin
                  query_ff.coord_x <= req_item.coord_x;
                  query_ff.coord_y <= req_item.coord_y;
                  limit_ff         <= limit_in;
                  scan_ff          <= '0;
                  found_ff         <= (limit_in != '0);
                  // empty search goes straight to done
                  state_ff         <= (limit_in != '0) ? ST_SCAN : ST_DONE;
               end
            end
            ST_SCAN: begin
               // one table read issued per cycle
               rd_valid_ff <= 1'b1;
               rd_first_ff <= (scan_ff == '0);
               rd_idx_ff   <= scan_ff;
               if (scan_last) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!rd_valid_ff && !dist_busy) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (rsp_load) begin
         rsp_item_ff.found         <= found_ff;
         rsp_item_ff.nearest_index <= found_ff ? npms_pkg::IndexBits'(dist_best_i) : '0;
         rsp_item_ff.best_distance <= found_ff ? dist_best_d : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // nothing in flight while a new item may be taken
   `NPMS_ASSERT_NOW(a_idle_quiet, clock, reset, req_ready,
      !rd_valid_ff && !dist_busy, "scan still in flight while ready")
   // scan address never passes the search limit
   `NPMS_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == ST_SCAN,
      int'(scan_ff) < int'(limit_ff), "scan index beyond limit")
   // a query with entries to search goes to scan next
   `NPMS_ASSERT_NEXT(a_query_scan, clock, reset,
      req_fire && req_item.req_type == npms_pkg::REQ_QUERY && limit_in != '0,
      state_ff == ST_SCAN, "query did not start a scan")
   // an empty search reports zeros
   `NPMS_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid_ff && !rsp_item_ff.found,
      rsp_item_ff.nearest_index == '0 && rsp_item_ff.best_distance == '0,
      "empty search with nonzero fields")

endmodule

// ----- hdl/npms_ram.sv -----
`timescale 1ns / 1ps

module npms_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AddrBits-1:0] waddr,
   input  logic [WIDTH-1:0]    wdata,
   input  logic [AddrBits-1:0] raddr,
   output logic [WIDTH-1:0]    rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/npms_dist_unit.sv -----
`timescale 1ns / 1ps

module npms_dist_unit #(
   parameter int IDX_BITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  npms_pkg::dist_ctl_type        ctl,
   input  logic [IDX_BITS-1:0]           idx,
   input  npms_pkg::pos_type             query,
   input  npms_pkg::pos_type             entry,
   output logic                          busy,
   output logic [IDX_BITS-1:0]           best_index,
   output logic [npms_pkg::DistBits-1:0] best_distance
);

   logic [npms_pkg::CoordBits-1:0] dx_in;
   logic [npms_pkg::CoordBits-1:0] dy_in;
   logic [npms_pkg::DistBits-1:0]  dist_in;

   logic                           v1_ff;
   logic                           first1_ff;
   logic [IDX_BITS-1:0]            idx1_ff;
   logic [npms_pkg::DistBits-1:0]  dist1_ff;
   logic [IDX_BITS-1:0]            best_i_ff;
   logic [npms_pkg::DistBits-1:0]  best_d_ff;

   // stage one: manhattan distance
   always_comb begin
      dx_in = (query.coord_x >= entry.coord_x) ? query.coord_x - entry.coord_x
                                               : entry.coord_x - query.coord_x;
      dy_in = (query.coord_y >= entry.coord_y) ? query.coord_y - entry.coord_y
                                               : entry.coord_y - query.coord_y;
      dist_in = {1'b0, dx_in} + {1'b0, dy_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
      end
      first1_ff <= ctl.first;
      idx1_ff   <= idx;
      dist1_ff  <= dist_in;
      // stage two: keep strictly closer, so lowest index wins a tie
      if (v1_ff && (first1_ff || dist1_ff < best_d_ff)) begin
         best_d_ff <= dist1_ff;
         best_i_ff <= idx1_ff;
      end
   end

   assign busy          = v1_ff;
   assign best_index    = best_i_ff;
   assign best_distance = best_d_ff;

endmodule
